// File: src/sorted_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue: package
// Transfer types, status codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               op;
    logic signed [15:0] job_priority;
    logic        [15:0] job_payload;
  } spq_in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [15:0] popped_priority;
    logic        [15:0] popped_payload;
    logic        [4:0]  occupancy;
  } spq_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_job;    // latch request, preset result
    logic [1:0] res_status;  // status preset on load_job
    logic       rd_head;     // read at head instead of slot below pointer
    logic       wr_en;       // write at pointer
    logic       wr_new;      // write the new job instead of the shifted entry
    logic       ptr_dec;     // step pointer toward head
    logic       push_commit; // grow queue by one
    logic       pop_commit;  // capture head, shrink queue by one
    logic       load_out;    // load output register
  } spq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_head;  // pointer reached head slot
    logic higher;   // read entry outranks the new job
  } spq_sts_t;

endpackage

`default_nettype wire

// File: src/spq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted priority queue: datapath
// Circular entry memory with head/tail pointers, insertion pointer and
// result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire spq_in_t  in_item,
  input  wire spq_cmd_t cmd,
  output spq_sts_t      sts,
  output spq_out_t      out_item
);

  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_BITS = (PAYLOAD_BITS < 16) ? PAYLOAD_BITS : 16;
  localparam int ENTRY_W    = 16 + STORE_BITS;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] ptr_below;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;
  logic [CNT_W-1:0] count;

  spq_in_t            job;
  logic [1:0]         res_status;
  logic signed [15:0] res_pri;
  logic [15:0]        res_pay;

  logic signed [15:0] rd_pri;

  assign ptr_below = (ptr == '0) ? IDX_W'(QUEUE_DEPTH - 1) : ptr - 1'b1;
  assign head_inc  = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  assign rd_addr = cmd.rd_head ? head : ptr_below;
  assign rd_pri  = $signed(rdata[ENTRY_W-1 -: 16]);
  assign wr_data = cmd.wr_new ? {job.job_priority, job.job_payload[STORE_BITS-1:0]} : rdata;

  assign sts.full    = (count == CNT_W'(QUEUE_DEPTH));
  assign sts.empty   = (count == '0);
  assign sts.at_head = (ptr == head);
  assign sts.higher  = (rd_pri > job.job_priority);

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push_commit) begin
        tail  <= tail_inc;
        count <= count + 1'b1;
      end else if (cmd.pop_commit) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_job) begin
      job        <= in_item;
      ptr        <= tail;
      res_status <= cmd.res_status;
      res_pri    <= '0;
      res_pay    <= '0;
    end else begin
      if (cmd.ptr_dec) begin
        ptr <= ptr_below;
      end
      if (cmd.pop_commit) begin
        res_pri <= rd_pri;
        res_pay <= 16'(rdata[STORE_BITS-1:0]);
      end
    end
    if (cmd.load_out) begin
      out_item.status          <= res_status;
      out_item.popped_priority <= res_pri;
      out_item.popped_payload  <= res_pay;
      out_item.occupancy       <= 5'(count);
    end
  end

endmodule

`default_nettype wire

// File: src/spq_controller.sv
// ----------------------------------------------------------------------------
// Sorted priority queue: controller
// Sequences push insertion scan, pop and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_controller
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire spq_sts_t sts,
  output spq_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH_RD  = 3'd1;
  localparam logic [2:0] S_PUSH_CMP = 3'd2;
  localparam logic [2:0] S_POP_RD   = 3'd3;
  localparam logic [2:0] S_POP_CAP  = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_job = 1'b1;
          if (in_op == OP_PUSH) begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
              state_next     = S_DONE;
            end else begin
              cmd.res_status = ST_OK;
              state_next     = S_PUSH_RD;
            end
          end else begin
            if (sts.empty) begin
              cmd.res_status = ST_EMPTY;
              state_next     = S_DONE;
            end else begin
              cmd.res_status = ST_OK;
              state_next     = S_POP_RD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        if (sts.at_head) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_new      = 1'b1;
          cmd.push_commit = 1'b1;
          state_next      = S_DONE;
        end else begin
          state_next = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.higher) begin
          cmd.wr_new      = 1'b1;
          cmd.push_commit = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.ptr_dec = 1'b1;
          state_next  = S_PUSH_RD;
        end
      end
      S_POP_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_POP_CAP;
      end
      S_POP_CAP: begin
        cmd.pop_commit = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: src/sorted_priority_queue_unit.sv
// Sequencing: a pop reads the head slot (S_POP_RD), captures it (S_POP_CAP),
//   then loads the result (S_DONE); a push runs a tail-to-head insertion scan
//   that reads (S_PUSH_RD) and moves back (S_PUSH_CMP) each entry that does
//   not outrank the job, until the job lands or reaches the head; a rejected
//   push or empty pop goes straight to S_DONE, where the result waits out a stall.
// Flow: one operation at a time, next transfer in the cycle after the result loads.
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded job queue kept in descending priority order; pop returns the head.
// Reset: synchronous, active high; empties the queue, entry RAM not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire spq_in_t in_item,
  output logic         out_valid,
  input  wire logic    out_ready,
  output spq_out_t     out_item
);

  // Entries live in a circular RAM between head and tail pointers. A pop
  // reads the head slot and advances head. A push walks from the tail toward
  // the head: each entry that does not outrank the new job moves one slot
  // back, and the new job drops into the gap, ahead of equal priorities.
  // Results sit in an output register, so a new transfer is taken while the
  // previous result still waits.

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// File: src/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue: port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_unit_assert.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire spq_in_t  in_item,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire spq_out_t out_item
);

  `SPQ_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready,
    "second transfer taken while busy")
  `SPQ_ASSERT(a_in_hold, (in_valid && !in_ready) |=> (in_valid && $stable(in_item)),
    "waiting request changed")
  `SPQ_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_item)),
    "stalled result changed")
  `SPQ_ASSERT(a_full_count,
    (out_valid && out_item.status == ST_FULL) |-> (out_item.occupancy == 5'(QUEUE_DEPTH)),
    "full reject without full queue")
  `SPQ_ASSERT(a_empty_zero,
    (out_valid && out_item.status == ST_EMPTY) |-> (out_item.occupancy == 5'd0 &&
      out_item.popped_priority == 16'sd0 && out_item.popped_payload == 16'd0),
    "empty pop result not zero")

endmodule

bind sorted_priority_queue_unit spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
